// ===== rtl/core/btn_mtg_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// btn_mtg_pkg
// shared types and codes for the button multi-tap gesture detector
// ----------------------------------------------------------------------------
package btn_mtg_pkg;

    localparam int CFG_INDEX_W = 4;
    localparam int CFG_DATA_W  = 16;
    localparam int GESTURE_W   = 3;
    localparam int TAP_W       = 2;

    typedef logic [CFG_INDEX_W-1:0] cfg_idx_t;
    typedef logic [CFG_DATA_W-1:0]  cfg_data_t;
    typedef logic [GESTURE_W-1:0]   gesture_t;
    typedef logic [TAP_W-1:0]       tap_t;

    // register map
    localparam cfg_idx_t CFG_ACTIVE_LEVEL   = cfg_idx_t'(0);
    localparam cfg_idx_t CFG_DEBOUNCE_TICKS = cfg_idx_t'(1);
    localparam cfg_idx_t CFG_LONG_TICKS     = cfg_idx_t'(2);
    localparam cfg_idx_t CFG_WINDOW_TICKS   = cfg_idx_t'(3);

    // register reset values
    localparam logic      RST_ACTIVE_LEVEL   = 1'b1;
    localparam cfg_data_t RST_DEBOUNCE_TICKS = cfg_data_t'(50);
    localparam cfg_data_t RST_LONG_TICKS     = cfg_data_t'(600);
    localparam cfg_data_t RST_WINDOW_TICKS   = cfg_data_t'(300);

    // gesture codes
    localparam gesture_t GEST_NONE   = gesture_t'(0);
    localparam gesture_t GEST_SHORT1 = gesture_t'(1);
    localparam gesture_t GEST_LONG1  = gesture_t'(2);
    localparam gesture_t GEST_SHORT2 = gesture_t'(3);
    localparam gesture_t GEST_LONG2  = gesture_t'(4);
    localparam gesture_t GEST_SHORT3 = gesture_t'(5);
    localparam gesture_t GEST_LONG3  = gesture_t'(6);

    localparam tap_t TAP_MAX = tap_t'(3);

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_PRESSED,
        PH_WINDOW
    } phase_t;

    // what the state update decided for this tick
    typedef struct packed {
        logic report;
        logic is_long;
        logic clear_last;
    } step_evt_t;

endpackage

// ===== rtl/core/btn_mtg_cfg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// btn_mtg_cfg
// configuration registers and clipped timer thresholds
// ----------------------------------------------------------------------------
module btn_mtg_cfg #(
    parameter int TIMER_BITS = 16
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_valid,
    input  btn_mtg_pkg::cfg_idx_t  cfg_index,
    input  btn_mtg_pkg::cfg_data_t cfg_data,
    output logic                   active_level,
    output logic [TIMER_BITS-1:0]  deb_thr,
    output logic [TIMER_BITS-1:0]  lng_thr,
    output logic [TIMER_BITS-1:0]  win_thr
);
    import btn_mtg_pkg::*;

    localparam int CW = (TIMER_BITS > CFG_DATA_W) ? TIMER_BITS : CFG_DATA_W;
    localparam logic [CW-1:0] TMAX_EXT = {CW{1'b1}} >> (CW - TIMER_BITS);

    logic      active_level_reg;
    cfg_data_t debounce_reg;
    cfg_data_t long_reg;
    cfg_data_t window_reg;

    // zero acts as one, anything above the timer range clips to its top
    function automatic logic [TIMER_BITS-1:0] clip_thr(input cfg_data_t v);
        logic [CW-1:0] ve;
        logic [CW-1:0] r;
        ve = CW'(v);
        if (ve == '0)
            r = CW'(1);
        else if (ve > TMAX_EXT)
            r = TMAX_EXT;
        else
            r = ve;
        return r[TIMER_BITS-1:0];
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_level_reg <= RST_ACTIVE_LEVEL;
            debounce_reg     <= RST_DEBOUNCE_TICKS;
            long_reg         <= RST_LONG_TICKS;
            window_reg       <= RST_WINDOW_TICKS;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_ACTIVE_LEVEL:   active_level_reg <= cfg_data[0];
                CFG_DEBOUNCE_TICKS: debounce_reg     <= cfg_data;
                CFG_LONG_TICKS:     long_reg         <= cfg_data;
                CFG_WINDOW_TICKS:   window_reg       <= cfg_data;
                default:            ;
            endcase
        end
    end

    assign active_level = active_level_reg;
    assign deb_thr      = clip_thr(debounce_reg);
    assign lng_thr      = clip_thr(long_reg);
    assign win_thr      = clip_thr(window_reg);

endmodule

// ===== rtl/core/btn_mtg_fsm.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// btn_mtg_fsm
// press / window state machine with its timers and gesture report logic
// ----------------------------------------------------------------------------
module btn_mtg_fsm #(
    parameter int TIMER_BITS = 16
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  step,
    input  logic                  act,
    input  logic [TIMER_BITS-1:0] deb_thr,
    input  logic [TIMER_BITS-1:0] lng_thr,
    input  logic [TIMER_BITS-1:0] win_thr,
    output btn_mtg_pkg::gesture_t gesture
);
    import btn_mtg_pkg::*;

    localparam logic [TIMER_BITS-1:0] TMAX = {TIMER_BITS{1'b1}};

    phase_t                phase_reg, phase_next;
    tap_t                  tap_reg, tap_next;
    logic [TIMER_BITS-1:0] ptimer_reg, ptimer_next;
    logic [TIMER_BITS-1:0] wtimer_reg, wtimer_next;
    gesture_t              last_reg, last_next;

    step_evt_t             evt;
    logic [TIMER_BITS-1:0] pt_bump;
    logic [TIMER_BITS-1:0] wt_bump;
    tap_t                  tap_n;
    gesture_t              code;
    logic                  prev_long;

    assign pt_bump = (ptimer_reg == TMAX) ? ptimer_reg : ptimer_reg + 1'b1;
    assign wt_bump = (wtimer_reg == TMAX) ? wtimer_reg : wtimer_reg + 1'b1;

    // next state
    always_comb
    begin
        phase_next  = phase_reg;
        tap_next    = tap_reg;
        ptimer_next = ptimer_reg;
        wtimer_next = wtimer_reg;
        evt         = '0;
        unique case (phase_reg)
            PH_PRESSED:
            begin
                if (act)
                begin
                    ptimer_next = pt_bump;
                    if (pt_bump >= lng_thr)
                    begin
                        evt.report  = 1'b1;
                        evt.is_long = 1'b1;
                    end
                end
                else if (tap_reg == TAP_MAX)
                begin
                    evt.report = 1'b1;
                end
                else
                begin
                    phase_next  = PH_WINDOW;
                    ptimer_next = '0;
                    wtimer_next = '0;
                end
            end
            PH_WINDOW:
            begin
                wtimer_next = wt_bump;
                // an active tick at expiry only counts while a debounce is running
                if (act && !(ptimer_reg == '0 && wt_bump >= win_thr))
                begin
                    ptimer_next = pt_bump;
                    if (pt_bump >= deb_thr)
                    begin
                        tap_next    = (tap_reg == TAP_MAX) ? TAP_MAX : tap_reg + 1'b1;
                        phase_next  = PH_PRESSED;
                        ptimer_next = '0;
                    end
                end
                else if (act)
                begin
                    evt.report = 1'b1;
                end
                else
                begin
                    ptimer_next = '0;
                    if (wt_bump >= win_thr)
                        evt.report = 1'b1;
                end
            end
            PH_IDLE:
            begin
                if (act)
                begin
                    ptimer_next = pt_bump;
                    if (pt_bump >= deb_thr)
                    begin
                        tap_next    = tap_t'(1);
                        phase_next  = PH_PRESSED;
                        ptimer_next = '0;
                    end
                end
                else
                begin
                    ptimer_next    = '0;
                    tap_next       = '0;
                    evt.clear_last = 1'b1;
                end
            end
            default:
            begin
                phase_next = PH_IDLE;
            end
        endcase
        if (evt.report)
        begin
            phase_next  = PH_IDLE;
            tap_next    = '0;
            ptimer_next = '0;
            wtimer_next = '0;
        end
    end

    // gesture word and remembered report
    always_comb
    begin
        tap_n     = (tap_reg == '0) ? tap_t'(1) : tap_reg;
        prev_long = (last_reg != GEST_NONE) && !last_reg[0];
        code      = evt.is_long ? {tap_n, 1'b0} : {tap_n, 1'b0} - gesture_t'(1);
        gesture   = GEST_NONE;
        last_next = last_reg;
        if (evt.report)
        begin
            if (evt.is_long)
            begin
                // held long press keeps repeating the first long code
                gesture   = prev_long ? last_reg : code;
                last_next = gesture;
            end
            else if (prev_long)
            begin
                last_next = GEST_NONE;
            end
            else
            begin
                gesture   = code;
                last_next = code;
            end
        end
        else if (evt.clear_last)
        begin
            last_next = GEST_NONE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_IDLE;
            tap_reg    <= '0;
            ptimer_reg <= '0;
            wtimer_reg <= '0;
            last_reg   <= GEST_NONE;
        end
        else if (step)
        begin
            phase_reg  <= phase_next;
            tap_reg    <= tap_next;
            ptimer_reg <= ptimer_next;
            wtimer_reg <= wtimer_next;
            last_reg   <= last_next;
        end
    end

endmodule

// ===== rtl/core/button_multi_tap_gesture_detector_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// button_multi_tap_gesture_detector_core
// debounced single/double/triple short and long press detector
// ----------------------------------------------------------------------------
// Each tick word carries one sampled pin level and yields exactly one gesture
// word (0 when nothing is reported). The block takes one tick word per clock
// cycle unless tick_stall is high; a word passes the input register and then
// the state update, which loads the gesture register. The state update loop
// (timer bump, threshold compare, phase select) sets the rate. Tick words keep
// flowing while the gesture register holds an untaken word as long as the
// input register can drain.
// Configuration writes are taken at once (cfg_ready is always high) and
// should be made only while no tick word is in flight.
// ----------------------------------------------------------------------------
module button_multi_tap_gesture_detector_core #(
    parameter int TIMER_BITS = 16
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   tick_valid,
    output logic                   tick_stall,
    input  logic                   pin_level,
    output logic                   gesture_valid,
    input  logic                   gesture_stall,
    output btn_mtg_pkg::gesture_t  gesture,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  btn_mtg_pkg::cfg_idx_t  cfg_index,
    input  btn_mtg_pkg::cfg_data_t cfg_data
);
    import btn_mtg_pkg::*;

    logic                  s1_valid_reg, s1_valid_next;
    logic                  pin_reg;
    logic                  out_valid_reg, out_valid_next;
    gesture_t              gesture_reg;

    logic                  active_level;
    logic [TIMER_BITS-1:0] deb_thr;
    logic [TIMER_BITS-1:0] lng_thr;
    logic [TIMER_BITS-1:0] win_thr;
    logic                  out_free;
    logic                  step;
    logic                  tick_take;
    gesture_t              step_gesture;

    assign cfg_ready = 1'b1;

    assign out_free   = !out_valid_reg || !gesture_stall;
    assign step       = s1_valid_reg && out_free;
    assign tick_stall = s1_valid_reg && !out_free;
    assign tick_take  = tick_valid && !tick_stall;

    btn_mtg_cfg #(
        .TIMER_BITS (TIMER_BITS)
    ) u_cfg (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .active_level (active_level),
        .deb_thr      (deb_thr),
        .lng_thr      (lng_thr),
        .win_thr      (win_thr)
    );

    btn_mtg_fsm #(
        .TIMER_BITS (TIMER_BITS)
    ) u_fsm (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (step),
        .act     (pin_reg == active_level),
        .deb_thr (deb_thr),
        .lng_thr (lng_thr),
        .win_thr (win_thr),
        .gesture (step_gesture)
    );

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (tick_take)
            s1_valid_next = 1'b1;
        else if (step)
            s1_valid_next = 1'b0;

        out_valid_next = out_valid_reg;
        if (step)
            out_valid_next = 1'b1;
        else if (!gesture_stall)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (tick_take)
            pin_reg <= pin_level;
        if (step)
            gesture_reg <= step_gesture;
    end

    assign gesture_valid = out_valid_reg;
    assign gesture       = gesture_reg;

endmodule

// ===== rtl/core/btn_mtg_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// btn_mtg_checker
// port-level checks for the gesture detector
// ----------------------------------------------------------------------------
module btn_mtg_checker (
    input logic                   clk,
    input logic                   rst_n,
    input logic                   tick_valid,
    input logic                   tick_stall,
    input logic                   gesture_valid,
    input logic                   gesture_stall,
    input btn_mtg_pkg::gesture_t  gesture,
    input logic                   cfg_valid,
    input logic                   cfg_ready
);
    import btn_mtg_pkg::*;

    // a held gesture word stays put
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        gesture_valid && gesture_stall |=> gesture_valid && $stable(gesture))
        else $error("gesture word changed while stalled");

    // only defined codes come out
    a_code_range: assert property (@(posedge clk) disable iff (!rst_n)
        gesture_valid |-> gesture <= GEST_LONG3)
        else $error("gesture code out of range");

    // input backpressure only arises from a full, stalled result register
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        tick_stall |-> gesture_valid && gesture_stall)
        else $error("tick stall without a blocked gesture word");

    // a stall is not held once the result side frees up
    a_stall_release: assert property (@(posedge clk) disable iff (!rst_n)
        tick_stall && !gesture_stall |=> !tick_stall)
        else $error("tick stall held after result register drained");

    // configuration is never back-pressured
    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid |-> cfg_ready)
        else $error("config write refused");

endmodule

bind button_multi_tap_gesture_detector_core btn_mtg_checker u_btn_mtg_checker (.*);
